@@ sv/aip_pkg.sv @@
`default_nettype none

package aip_pkg;

   // parse phases
   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_SIGNED = 3'd1;
   localparam logic [2:0] PH_ZERO   = 3'd2;
   localparam logic [2:0] PH_PREFIX = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;

   // number bases
   localparam logic [4:0] BASE_2  = 5'd2;
   localparam logic [4:0] BASE_8  = 5'd8;
   localparam logic [4:0] BASE_10 = 5'd10;
   localparam logic [4:0] BASE_16 = 5'd16;

   // special characters
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] CHAR_UP_O  = 8'h4F;
   localparam logic [7:0] CHAR_LO_O  = 8'h6F;
   localparam logic [7:0] CHAR_UP_B  = 8'h42;
   localparam logic [7:0] CHAR_LO_B  = 8'h62;

   // value returned for a character that is no digit
   localparam logic [4:0] NOT_DIGIT = 5'd16;

   localparam int unsigned VALUE_W = 64;

   // one parsed result word
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               parse_error;
   } result_type;

   // digit value of a character, NOT_DIGIT if it is none
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] d;
      d = NOT_DIGIT;
      if (c inside {[8'h30:8'h39]}) begin
         d = 5'(c - 8'h30);
      end else if (c inside {[8'h41:8'h46]}) begin
         d = 5'(c - 8'h41 + 8'd10);
      end else if (c inside {[8'h61:8'h66]}) begin
         d = 5'(c - 8'h61 + 8'd10);
      end
      return d;
   endfunction

endpackage

`default_nettype wire

@@ sv/aip_parse.sv @@
`default_nettype none

module aip_parse #(
   parameter int unsigned RESULT_WIDTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_valid,
   input  wire logic [7:0]           step_char,
   input  wire logic                 narrow,
   output logic                      result_valid,
   output aip_pkg::result_type       result
);

   localparam int unsigned NARROW_W = (RESULT_WIDTH < 32) ? RESULT_WIDTH : 32;

   logic [2:0]              phase_ff, phase_in;
   logic [4:0]              base_ff, base_in;
   logic                    negative_ff, negative_in;
   logic [RESULT_WIDTH-1:0] acc_ff, acc_in;
   logic                    error_ff, error_in;

   logic [4:0]              digit;
   logic                    digit_ok;
   logic [RESULT_WIDTH-1:0] acc_digit;
   logic [RESULT_WIDTH-1:0] acc_neg;
   logic signed [RESULT_WIDTH-1:0] full_s;
   logic signed [NARROW_W-1:0]     narrow_s;
   logic                    is_term;
   logic                    bad;

   assign digit    = aip_pkg::digit_value(step_char);
   assign digit_ok = (digit < base_ff);
   assign is_term  = (step_char == aip_pkg::CHAR_NUL);

   // accumulator times base plus digit; digit is below base so shifts just concat
   always_comb begin
      case (base_ff)
         aip_pkg::BASE_16: acc_digit = {acc_ff[RESULT_WIDTH-5:0], digit[3:0]};
         aip_pkg::BASE_8:  acc_digit = {acc_ff[RESULT_WIDTH-4:0], digit[2:0]};
         aip_pkg::BASE_2:  acc_digit = {acc_ff[RESULT_WIDTH-2:0], digit[0]};
         default: acc_digit = (acc_ff << 3) + (acc_ff << 1) + RESULT_WIDTH'(digit);
      endcase
   end

   // final value: negate, then sign-extend from full or narrow width
   assign acc_neg  = negative_ff ? (RESULT_WIDTH'(0) - acc_ff) : acc_ff;
   assign full_s   = acc_neg;
   assign narrow_s = acc_neg[NARROW_W-1:0];
   assign bad      = error_ff || (phase_ff == aip_pkg::PH_START)
                     || (phase_ff == aip_pkg::PH_SIGNED)
                     || (phase_ff == aip_pkg::PH_PREFIX);

   always_comb begin
      result_valid       = step_valid && is_term;
      result.parse_error = bad;
      if (bad) begin
         result.value = '0;
      end else if (narrow) begin
         result.value = aip_pkg::VALUE_W'(narrow_s);
      end else begin
         result.value = aip_pkg::VALUE_W'(full_s);
      end
   end

   // next state for one character
   always_comb begin
      phase_in    = phase_ff;
      base_in     = base_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;
      error_in    = error_ff;
      if (step_valid) begin
         if (is_term) begin
            phase_in    = aip_pkg::PH_START;
            base_in     = aip_pkg::BASE_10;
            negative_in = 1'b0;
            acc_in      = '0;
            error_in    = 1'b0;
         end else if (!error_ff) begin
            case (phase_ff)
               aip_pkg::PH_START, aip_pkg::PH_SIGNED: begin
                  if (step_char == aip_pkg::CHAR_MINUS && phase_ff == aip_pkg::PH_START) begin
                     negative_in = 1'b1;
                     phase_in    = aip_pkg::PH_SIGNED;
                  end else if (step_char == aip_pkg::CHAR_ZERO) begin
                     acc_in   = '0;
                     phase_in = aip_pkg::PH_ZERO;
                  end else if (digit_ok) begin
                     acc_in   = acc_digit;
                     phase_in = aip_pkg::PH_DIGITS;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               aip_pkg::PH_ZERO: begin
                  if (step_char == aip_pkg::CHAR_UP_X || step_char == aip_pkg::CHAR_LO_X) begin
                     base_in  = aip_pkg::BASE_16;
                     phase_in = aip_pkg::PH_PREFIX;
                  end else if (step_char == aip_pkg::CHAR_UP_O
                               || step_char == aip_pkg::CHAR_LO_O) begin
                     base_in  = aip_pkg::BASE_8;
                     phase_in = aip_pkg::PH_PREFIX;
                  end else if (step_char == aip_pkg::CHAR_UP_B
                               || step_char == aip_pkg::CHAR_LO_B) begin
                     base_in  = aip_pkg::BASE_2;
                     phase_in = aip_pkg::PH_PREFIX;
                  end else if (digit_ok) begin
                     acc_in   = acc_digit;
                     phase_in = aip_pkg::PH_DIGITS;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               aip_pkg::PH_PREFIX, aip_pkg::PH_DIGITS: begin
                  if (digit_ok) begin
                     acc_in   = acc_digit;
                     phase_in = aip_pkg::PH_DIGITS;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               default: begin
                  error_in = 1'b1;
               end
            endcase
         end
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= aip_pkg::PH_START;
         base_ff     <= aip_pkg::BASE_10;
         negative_ff <= 1'b0;
         acc_ff      <= '0;
         error_ff    <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         base_ff     <= base_in;
         negative_ff <= negative_in;
         acc_ff      <= acc_in;
         error_ff    <= error_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ascii_integer_parser.sv @@
// Streaming integer parser: one ASCII character per word on req_, one
// result word on rsp_ for each zero byte that ends a string. Accepts an
// optional '-', then an optional 0x/0o/0b prefix (either case), then digits
// of that base (default ten). rsp_parse_error is set when no digit was seen
// or a bad character appeared, and rsp_value is then zero. The value wraps
// modulo 2^RESULT_WIDTH and is sign-extended to 64 bits; csr_write_data = 1
// truncates it to 32 bits first. A character is
// registered, run through the parse step (shift or times-ten
// add) and, at the terminator, registered into the result stage, so one
// word a cycle is sustained while rsp_stall is low. A terminator passes the
// input register and then the result register before its result is valid.
// Reset is synchronous and needs no clearing pass.
`default_nettype none

module ascii_integer_parser #(
   parameter int unsigned RESULT_WIDTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_value,
   output logic             rsp_parse_error,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data
);

   logic                narrow_ff;
   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_char_ff;
   logic                out_valid_ff, out_valid_in;
   aip_pkg::result_type out_ff;
   logic                advance;
   logic                core_valid;
   aip_pkg::result_type core_result;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         narrow_ff <= 1'b0;
      end else if (csr_write_enable) begin
         narrow_ff <= csr_write_data;
      end
   end

   // a terminator moves on only when the result register can take it
   assign advance   = in_valid_ff && ((in_char_ff != aip_pkg::CHAR_NUL)
                                      || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // input register
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_char_ff <= req_char_code;
      end
   end

   aip_parse #(
      .RESULT_WIDTH (RESULT_WIDTH)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (advance),
      .step_char    (in_char_ff),
      .narrow       (narrow_ff),
      .result_valid (core_valid),
      .result       (core_result)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (core_valid) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_valid) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_value       = out_ff.value;
   assign rsp_parse_error = out_ff.parse_error;

endmodule

`default_nettype wire
